/* hw/rtl/sprite_alpha_over_canvas_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the canvas checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ALPHA_OVER_CANVAS_MACROS_SVH
`define SPRITE_ALPHA_OVER_CANVAS_MACROS_SVH

// Clocked implication with asynchronous reset disable.
`define SAOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication with asynchronous reset disable.
`define SAOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/saoc_pkg.sv */
// ----------------------------------------------------------------------------
// saoc_pkg
// Types and constants shared by the sprite canvas modules.
// ----------------------------------------------------------------------------
package saoc_pkg;

  localparam int unsigned MaxSide   = 256;
  localparam int unsigned SwapSlots = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 32;

  localparam logic [1:0] OpBlend = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;

  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCount  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPair0  = 3'd3;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StAlpha,
    StMul,
    StDiv,
    StWrite,
    StOut
  } state_e;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [16:0] num_r;
    logic [16:0] num_g;
    logic [16:0] num_b;
    logic [8:0]  den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q_r;
    logic [7:0] q_g;
    logic [7:0] q_b;
  } div_rsp_t;

endpackage

/* hw/rtl/sprite_alpha_over_canvas.sv */
// ----------------------------------------------------------------------------
// sprite_alpha_over_canvas
// RGBA canvas with non-premultiplied alpha-over blending and swap chain.
// ----------------------------------------------------------------------------
// One transaction at a time. A clipped item goes straight to the output stage;
// a read, write, skip or opaque blend passes the read, alpha and write states,
// and a partial blend also passes the multiply state and a restoring divide by
// the output alpha. The next item can be accepted in the cycle after a result
// is loaded. After reset a clearing pass zeroes the canvas memory before the
// first item is taken. The result waits in an output register until taken,
// while the next item may enter.
module sprite_alpha_over_canvas #(
  parameter int unsigned MaxSide   = saoc_pkg::MaxSide,
  parameter int unsigned SwapSlots = saoc_pkg::SwapSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], pos_x[11:2], pos_y[21:12], src_red[29:22], src_green[37:30],
  // src_blue[45:38], src_alpha[53:46], zero fill [63:54]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0] m_axis_tdata,
  // off_canvas
  output logic        m_axis_tuser
);

  localparam int unsigned SideW = $clog2(MaxSide);
  localparam int unsigned AddrW = 2 * SideW;
  localparam int unsigned Depth = MaxSide * MaxSide;

  saoc_pkg::state_e state_q, state_d;

  logic [8:0] width_q, height_q;
  logic [2:0] count_q;
  logic [SwapSlots-1:0][47:0] pairs_q;

  logic [31:0]      mem [Depth];
  logic [31:0]      rdata_q;
  logic [AddrW-1:0] clr_q;
  logic             clr_busy_q;

  logic [1:0]       op_q;
  logic [AddrW-1:0] addr_q;
  logic [31:0]      src_q;
  logic [31:0]      px_q, px_d;
  logic [15:0]      daia_q;
  logic [8:0]       oa_q;
  logic             ovalid_q;
  logic [31:0]      odata_q;
  logic             ooff_q;
  logic             ouser_q;

  saoc_pkg::div_req_t dreq;
  saoc_pkg::div_rsp_t drsp;
  logic [31:0]        swapped;

  logic [1:0]  in_op;
  logic signed [9:0] in_x, in_y;
  logic [31:0] in_src;
  logic [9:0]  w_eff, h_eff;
  logic        clip;
  logic        take;
  logic        out_free;

  // Floor of x/255 by reciprocal multiplication, exact below 2^32 / 254.
  function automatic logic [16:0] div255(input logic [23:0] x);
    logic [55:0] p;
    p = (56'(x) << 24) + (56'(x) << 16) + (56'(x) << 8) + (56'(x) << 1);
    div255 = p[48:32];
  endfunction

  assign in_op  = s_axis_tdata[1:0];
  assign in_x   = s_axis_tdata[11:2];
  assign in_y   = s_axis_tdata[21:12];
  assign in_src = {s_axis_tdata[53:46], s_axis_tdata[29:22], s_axis_tdata[37:30],
                   s_axis_tdata[45:38]};

  assign w_eff = (32'(width_q) > MaxSide) ? 10'(MaxSide) : {1'b0, width_q};
  assign h_eff = (32'(height_q) > MaxSide) ? 10'(MaxSide) : {1'b0, height_q};
  assign clip  = in_x[9] || in_y[9] || ($unsigned(in_x) >= w_eff) ||
                 ($unsigned(in_y) >= h_eff);

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == saoc_pkg::StIdle) && !clr_busy_q;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      saoc_pkg::StIdle:  if (take) state_d = clip ? saoc_pkg::StOut : saoc_pkg::StRead;
      saoc_pkg::StRead:  state_d = saoc_pkg::StAlpha;
      saoc_pkg::StAlpha: begin
        if (op_q == saoc_pkg::OpBlend && src_q[31:24] != 8'd0 && src_q[31:24] != 8'd255)
          state_d = saoc_pkg::StMul;
        else state_d = saoc_pkg::StWrite;
      end
      saoc_pkg::StMul:   state_d = saoc_pkg::StDiv;
      saoc_pkg::StDiv:   if (drsp.done) state_d = saoc_pkg::StWrite;
      saoc_pkg::StWrite: state_d = saoc_pkg::StOut;
      saoc_pkg::StOut:   if (out_free) state_d = saoc_pkg::StIdle;
      default:           state_d = saoc_pkg::StIdle;
    endcase
  end

  // Blend arithmetic and divider requests.
  always_comb begin
    logic [7:0]  a;
    logic [8:0]  oa;
    a    = src_q[31:24];
    oa   = 9'(a) + 9'(div255(24'(daia_q)));
    px_d = px_q;
    dreq = '0;
    unique case (state_q)
      saoc_pkg::StAlpha: begin
        px_d = rdata_q;
        if (op_q == saoc_pkg::OpWrite) px_d = src_q;
        else if (op_q == saoc_pkg::OpBlend && a == 8'd255) px_d = src_q;
      end
      saoc_pkg::StMul: begin
        dreq.start = 1'b1;
        dreq.den   = oa;
        dreq.num_r = 17'(16'(src_q[23:16]) * 16'(a)) +
                     div255(24'(px_q[23:16]) * 24'(daia_q));
        dreq.num_g = 17'(16'(src_q[15:8]) * 16'(a)) +
                     div255(24'(px_q[15:8]) * 24'(daia_q));
        dreq.num_b = 17'(16'(src_q[7:0]) * 16'(a)) +
                     div255(24'(px_q[7:0]) * 24'(daia_q));
      end
      saoc_pkg::StDiv: begin
        if (drsp.done) px_d = {oa_q[7:0], drsp.q_r, drsp.q_g, drsp.q_b};
      end
      default: ;
    endcase
  end

  saoc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  saoc_swap #(.SwapSlots(SwapSlots)) u_swap (
    .px_i    (px_q),
    .count_i ((count_q > 3'(SwapSlots)) ? 3'(SwapSlots) : count_q),
    .pairs_i (pairs_q),
    .px_o    (swapped)
  );

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) mem[clr_q] <= '0;
    else if (state_q == saoc_pkg::StWrite) mem[addr_q] <= px_q;
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= in_op;
      addr_q <= {in_y[SideW-1:0], in_x[SideW-1:0]};
      src_q  <= in_src;
    end
    if (state_q == saoc_pkg::StAlpha) begin
      daia_q <= 16'(rdata_q[31:24]) * 16'(8'd255 - src_q[31:24]);
    end
    if (state_q == saoc_pkg::StMul) oa_q <= dreq.den;
    px_q <= px_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= saoc_pkg::StIdle;
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
      width_q    <= 9'd256;
      height_q   <= 9'd256;
      count_q    <= '0;
      pairs_q    <= '0;
      ovalid_q   <= 1'b0;
      odata_q    <= '0;
      ooff_q     <= 1'b0;
      ouser_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) clr_busy_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == saoc_pkg::RegWidth) width_q <= cfg_data_i[8:0];
        else if (cfg_index_i == saoc_pkg::RegHeight) height_q <= cfg_data_i[8:0];
        else if (cfg_index_i == saoc_pkg::RegCount) count_q <= cfg_data_i[2:0];
        else begin
          for (int i = 0; i < SwapSlots; i++) begin
            if (32'(cfg_index_i) == 32'(saoc_pkg::RegPair0) + i) pairs_q[i] <= cfg_data_i;
          end
        end
      end
      if (take && clip) ooff_q <= 1'b1;
      else if (take) ooff_q <= 1'b0;
      if (state_q == saoc_pkg::StOut && out_free) begin
        ovalid_q <= 1'b1;
        ouser_q  <= ooff_q;
        odata_q  <= ooff_q ? 32'd0 : {swapped[31:24], swapped[7:0], swapped[15:8],
                                      swapped[23:16]};
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

/* hw/rtl/saoc_div.sv */
// ----------------------------------------------------------------------------
// saoc_div
// Three parallel restoring dividers, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module saoc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  saoc_pkg::div_req_t  req_i,
  output saoc_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned NumW = 17;

  logic [NumW-1:0] qr_q, qr_d, qg_q, qg_d, qb_q, qb_d;
  logic [NumW-1:0] rr_q, rr_d, rg_q, rg_d, rb_q, rb_d;
  logic [NumW-1:0] nr_q, nr_d, ng_q, ng_d, nb_q, nb_d;
  logic [8:0]      den_q, den_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  function automatic logic [NumW-1:0] sat8(input logic [NumW-1:0] q);
    sat8 = (q > NumW'(255)) ? NumW'(255) : q;
  endfunction

  always_comb begin
    logic [NumW:0] tr, tg, tb;
    logic [NumW:0] dd;
    qr_d = qr_q; qg_d = qg_q; qb_d = qb_q;
    rr_d = rr_q; rg_d = rg_q; rb_d = rb_q;
    nr_d = nr_q; ng_d = ng_q; nb_d = nb_q;
    den_d = den_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    dd = {(NumW-8)'(0), den_q};
    tr = {rr_q, nr_q[NumW-1]};
    tg = {rg_q, ng_q[NumW-1]};
    tb = {rb_q, nb_q[NumW-1]};
    if (req_i.start) begin
      nr_d = req_i.num_r; ng_d = req_i.num_g; nb_d = req_i.num_b;
      rr_d = '0; rg_d = '0; rb_d = '0;
      qr_d = '0; qg_d = '0; qb_d = '0;
      den_d = req_i.den; cnt_d = 5'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      nr_d = nr_q << 1; ng_d = ng_q << 1; nb_d = nb_q << 1;
      if (tr >= dd) begin rr_d = NumW'(tr - dd); qr_d = {qr_q[NumW-2:0], 1'b1}; end
      else begin rr_d = NumW'(tr); qr_d = {qr_q[NumW-2:0], 1'b0}; end
      if (tg >= dd) begin rg_d = NumW'(tg - dd); qg_d = {qg_q[NumW-2:0], 1'b1}; end
      else begin rg_d = NumW'(tg); qg_d = {qg_q[NumW-2:0], 1'b0}; end
      if (tb >= dd) begin rb_d = NumW'(tb - dd); qb_d = {qb_q[NumW-2:0], 1'b1}; end
      else begin rb_d = NumW'(tb); qb_d = {qb_q[NumW-2:0], 1'b0}; end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q <= qr_d; qg_q <= qg_d; qb_q <= qb_d;
    rr_q <= rr_d; rg_q <= rg_d; rb_q <= rb_d;
    nr_q <= nr_d; ng_q <= ng_d; nb_q <= nb_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q_r  = 8'(sat8(qr_q));
  assign rsp_o.q_g  = 8'(sat8(qg_q));
  assign rsp_o.q_b  = 8'(sat8(qb_q));

endmodule

/* hw/rtl/saoc_swap.sv */
// ----------------------------------------------------------------------------
// saoc_swap
// Ordered rgb palette swap chain applied to a result pixel.
// ----------------------------------------------------------------------------
module saoc_swap #(
  parameter int unsigned SwapSlots = saoc_pkg::SwapSlots
) (
  input  logic [31:0]          px_i,
  input  logic [2:0]           count_i,
  input  logic [SwapSlots-1:0][47:0] pairs_i,
  output logic [31:0]          px_o
);

  always_comb begin
    logic [23:0] rgb;
    rgb = px_i[23:0];
    for (int i = 0; i < SwapSlots; i++) begin
      if ((32'(count_i) > i) && (rgb == pairs_i[i][47:24])) begin
        rgb = pairs_i[i][23:0];
      end
    end
    px_o = {px_i[31:24], rgb};
  end

endmodule

/* hw/rtl/saoc_checker.sv */
// ----------------------------------------------------------------------------
// saoc_checker
// Port-level checks on the canvas block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sprite_alpha_over_canvas_macros.svh"

module saoc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `SAOC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `SAOC_ASSERT_IMPL(a_clip_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0, "clipped result not zero")
  `SAOC_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind sprite_alpha_over_canvas saoc_checker u_saoc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* sim/sprite_alpha_over_canvas_tb.sv */
// ----------------------------------------------------------------------------
// sprite_alpha_over_canvas_tb
// Self-checking bench for the RGBA canvas. A local model of the canvas memory,
// the clip window and the swap chain predicts every result. Each stream
// transaction is compared field by field with the oldest prediction. Directed
// tests cover the corner cases. Random phases under varied settings and random
// stalls on both sides follow.
// ----------------------------------------------------------------------------
module sprite_alpha_over_canvas_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpReadAlt = 2'd3;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned HoldOffCycles = 500;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       off;
  } pixel_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [31:0] canvas_mem [saoc_pkg::MaxSide*saoc_pkg::MaxSide];
  logic [8:0]  cur_width;
  logic [8:0]  cur_height;
  logic [2:0]  cur_swaps;
  logic [47:0] cur_pair [saoc_pkg::SwapSlots];
  logic [23:0] palette [4];

  pixel_result_t pending_pixels[$];
  int          fail_count;
  int          idle_cycles;
  bit          hold_off_req;
  bit          no_gaps;
  bit          accepted;

  sprite_alpha_over_canvas uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int roll;
    roll = int'($urandom_range(99));
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return int'($urandom_range(3, 1));
    return int'($urandom_range(60, 10));
  endfunction

  function automatic logic [31:0] swap_chain(logic [31:0] px);
    int n;
    n = (int'(cur_swaps) > saoc_pkg::SwapSlots) ? saoc_pkg::SwapSlots : int'(cur_swaps);
    for (int i = 0; i < n; i++) begin
      if (px[23:0] == cur_pair[i][47:24]) px[23:0] = cur_pair[i][23:0];
    end
    return px;
  endfunction

  function automatic logic [7:0] blend_chan(int s, int d, int a, int da, int oa);
    int v;
    v = (s * a + (d * da * (255 - a)) / 255) / oa;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pixel_result_t draw_pixel(logic [1:0] op, logic signed [9:0] px_x,
                                               logic signed [9:0] px_y, logic [31:0] src);
    pixel_result_t res;
    int w, h, x, y, idx, a, da, oa;
    logic [31:0] px;
    w = (int'(cur_width) > saoc_pkg::MaxSide) ? saoc_pkg::MaxSide : int'(cur_width);
    h = (int'(cur_height) > saoc_pkg::MaxSide) ? saoc_pkg::MaxSide : int'(cur_height);
    x = px_x;
    y = px_y;
    res = '0;
    if (x < 0 || y < 0 || x >= w || y >= h) begin
      res.off = 1'b1;
      return res;
    end
    idx = y * saoc_pkg::MaxSide + x;
    px = canvas_mem[idx];
    a = int'(src[31:24]);
    if (op == saoc_pkg::OpWrite) begin
      px = src;
    end else if (op == saoc_pkg::OpBlend && a != 0) begin
      if (a == 255) begin
        px = src;
      end else begin
        da = int'(px[31:24]);
        oa = a + (da * (255 - a)) / 255;
        px = {oa[7:0], blend_chan(int'(src[23:16]), int'(px[23:16]), a, da, oa),
              blend_chan(int'(src[15:8]), int'(px[15:8]), a, da, oa),
              blend_chan(int'(src[7:0]), int'(px[7:0]), a, da, oa)};
      end
    end
    canvas_mem[idx] = px;
    px = swap_chain(px);
    res.red = px[23:16];
    res.green = px[15:8];
    res.blue = px[7:0];
    res.alpha = px[31:24];
    return res;
  endfunction

  task automatic send_item(logic [1:0] op, logic signed [9:0] x, logic signed [9:0] y,
                           logic [31:0] src);
    int gap;
    bit ok;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {10'b0, src[31:24], src[7:0], src[15:8], src[23:16], y, x, op};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    pending_pixels = {pending_pixels, draw_pixel(op, x, y, src)};
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] index, logic [47:0] value);
    bit ok;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    case (index)
      saoc_pkg::RegWidth:  cur_width = value[8:0];
      saoc_pkg::RegHeight: cur_height = value[8:0];
      saoc_pkg::RegCount:  cur_swaps = value[2:0];
      default:             cur_pair[index - saoc_pkg::RegPair0] = value;
    endcase
  endtask

  task automatic set_canvas(int w, int h);
    write_reg(saoc_pkg::RegWidth, 48'(w));
    write_reg(saoc_pkg::RegHeight, 48'(h));
  endtask

  function automatic logic [23:0] pick_rgb();
    if ($urandom_range(1)) return palette[$urandom_range(3)];
    return 24'($urandom());
  endfunction

  function automatic logic [7:0] pick_alpha();
    int roll;
    roll = int'($urandom_range(9));
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom());
  endfunction

  task automatic test_directed();
    send_item(saoc_pkg::OpRead, 10'sd0, 10'sd0, 32'hFFFF_FFFF);
    send_item(saoc_pkg::OpWrite, 10'sd0, 10'sd0, 32'h80_102030);
    send_item(saoc_pkg::OpRead, 10'sd0, 10'sd0, 32'h0);
    send_item(saoc_pkg::OpBlend, 10'sd0, 10'sd0, 32'h00_FFFFFF);
    send_item(saoc_pkg::OpBlend, 10'sd0, 10'sd0, 32'h7F_FF00FF);
    send_item(saoc_pkg::OpBlend, 10'sd0, 10'sd0, 32'h01_FFFFFF);
    send_item(saoc_pkg::OpBlend, 10'sd0, 10'sd0, 32'hFE_000000);
    send_item(saoc_pkg::OpBlend, 10'sd0, 10'sd0, 32'hFF_ABCDEF);
    send_item(saoc_pkg::OpBlend, 10'sd1, 10'sd0, 32'h40_FFFFFF);
    send_item(saoc_pkg::OpBlend, 10'sd1, 10'sd0, 32'hC0_FF8001);
    send_item(OpReadAlt, 10'sd1, 10'sd0, 32'hFFFF_FFFF);
    send_item(saoc_pkg::OpWrite, 10'sd255, 10'sd255, 32'hFFFF_FFFF);
    send_item(saoc_pkg::OpRead, 10'sd255, 10'sd255, 32'h0);
    send_item(saoc_pkg::OpWrite, -10'sd1, 10'sd0, 32'hFFFF_FFFF);
    send_item(saoc_pkg::OpBlend, 10'sd0, -10'sd1, 32'h80_FFFFFF);
    send_item(saoc_pkg::OpRead, -10'sd512, -10'sd512, 32'h0);
    send_item(saoc_pkg::OpWrite, 10'sd511, 10'sd511, 32'hFFFF_FFFF);
    send_item(saoc_pkg::OpRead, 10'sd256, 10'sd0, 32'h0);
    send_item(saoc_pkg::OpRead, 10'sd0, 10'sd256, 32'h0);
    send_item(saoc_pkg::OpBlend, 10'sd2, 10'sd3, 32'hFF_FFFFFF);
    send_item(saoc_pkg::OpBlend, 10'sd2, 10'sd3, 32'h01_000000);
  endtask

  task automatic test_canvas_size();
    set_canvas(1, 1);
    send_item(saoc_pkg::OpWrite, 10'sd0, 10'sd0, 32'h11_223344);
    send_item(saoc_pkg::OpRead, 10'sd1, 10'sd0, 32'h0);
    send_item(saoc_pkg::OpRead, 10'sd0, 10'sd1, 32'h0);
    set_canvas(0, 256);
    send_item(saoc_pkg::OpRead, 10'sd0, 10'sd0, 32'h0);
    set_canvas(256, 0);
    send_item(saoc_pkg::OpWrite, 10'sd0, 10'sd0, 32'hFFFF_FFFF);
    set_canvas(300, 511);
    send_item(saoc_pkg::OpRead, 10'sd255, 10'sd255, 32'h0);
    send_item(saoc_pkg::OpRead, 10'sd256, 10'sd10, 32'h0);
    send_item(saoc_pkg::OpRead, 10'sd10, 10'sd300, 32'h0);
    set_canvas(256, 256);
  endtask

  task automatic test_swap_chain();
    write_reg(saoc_pkg::RegPair0, {24'h102030, 24'h405060});
    write_reg(saoc_pkg::RegPair0 + 3'd1, {24'h405060, 24'h708090});
    write_reg(saoc_pkg::RegPair0 + 3'd2, {24'hAAAAAA, 24'hAAAAAA});
    write_reg(saoc_pkg::RegPair0 + 3'd3, {24'h000000, 24'hFFFFFF});
    write_reg(saoc_pkg::RegPair0 + 3'd4, {24'hFFFFFF, 24'h123456});
    for (int n = 0; n < 8; n += (n == 5) ? 2 : 1) begin
      write_reg(saoc_pkg::RegCount, 48'(n));
      send_item(saoc_pkg::OpWrite, 10'sd5, 10'sd5, 32'h80_102030);
      send_item(saoc_pkg::OpWrite, 10'sd6, 10'sd5, 32'h40_AAAAAA);
      send_item(saoc_pkg::OpRead, 10'sd7, 10'sd5, 32'h0);
      send_item(saoc_pkg::OpWrite, 10'sd8, 10'sd5, 32'hFF_405060);
    end
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_item(saoc_pkg::OpBlend, 10'(i % 3), 10'sd0, {pick_alpha(), pick_rgb()});
    end
    drain();
    for (int i = 0; i < 30; i++) begin
      send_item(2'($urandom_range(3)), 10'(i % 4), 10'sd1, {pick_alpha(), pick_rgb()});
    end
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int w, h, span_x, span_y, roll;
    logic [1:0] op;
    logic signed [9:0] x, y;
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 4; k++) palette[k] = 24'($urandom());
      w = (phase == 0) ? 256 : (phase == 1) ? 511 : int'($urandom_range(40, 1));
      h = (phase == 0) ? 256 : (phase == 1) ? 300 : int'($urandom_range(40, 1));
      set_canvas(w, h);
      for (int k = 0; k < saoc_pkg::SwapSlots; k++) begin
        write_reg(saoc_pkg::RegPair0 + 3'(k), {pick_rgb(), pick_rgb()});
      end
      write_reg(saoc_pkg::RegCount, 48'($urandom_range(7)));
      no_gaps = (phase == 3);
      span_x = (w > 8) ? 8 : w;
      span_y = (h > 8) ? 8 : h;
      for (int i = 0; i < 250; i++) begin
        roll = int'($urandom_range(99));
        op = (roll < 55) ? saoc_pkg::OpBlend : (roll < 75) ? saoc_pkg::OpWrite :
             (roll < 93) ? saoc_pkg::OpRead : OpReadAlt;
        roll = int'($urandom_range(99));
        if (roll < 80) begin
          x = 10'($urandom_range(span_x - 1));
          y = 10'($urandom_range(span_y - 1));
        end else if (roll < 90) begin
          x = 10'($urandom_range(((w > 256) ? 256 : w)));
          y = 10'($urandom_range(((h > 256) ? 256 : h)));
        end else begin
          x = 10'($urandom());
          y = 10'($urandom());
        end
        send_item(op, x, y, {pick_alpha(), pick_rgb()});
      end
      no_gaps = 1'b0;
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    pixel_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result %h off=%b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $error("out_red: expected %h, got %h", want.red, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("out_green: expected %h, got %h", want.green, m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $error("out_blue: expected %h, got %h", want.blue, m_axis_tdata[23:16]);
          fail_count++;
        end
        if (m_axis_tdata[31:24] !== want.alpha) begin
          $error("out_alpha: expected %h, got %h", want.alpha, m_axis_tdata[31:24]);
          fail_count++;
        end
        if (m_axis_tuser !== want.off) begin
          $error("off_canvas: expected %b, got %b", want.off, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    accepted <= (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid_i && cfg_ready_o);
  end

  always @(posedge clk_i) begin
    if (accepted) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    no_gaps = 1'b0;
    accepted = 1'b0;
    cur_width = 9'd256;
    cur_height = 9'd256;
    cur_swaps = '0;
    for (int i = 0; i < saoc_pkg::SwapSlots; i++) cur_pair[i] = '0;
    for (int i = 0; i < saoc_pkg::MaxSide * saoc_pkg::MaxSide; i++) canvas_mem[i] = '0;
    for (int i = 0; i < 4; i++) palette[i] = 24'($urandom());
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_canvas_size();
    test_swap_chain();
    test_backpressure();
    test_random();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sprite_alpha_over_canvas.f */
+incdir+hw/rtl
hw/rtl/saoc_pkg.sv
hw/rtl/saoc_div.sv
hw/rtl/saoc_swap.sv
hw/rtl/sprite_alpha_over_canvas.sv
hw/rtl/saoc_checker.sv
sim/sprite_alpha_over_canvas_tb.sv
